// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define XPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("xps assertion failed");

// expression must never be true outside reset
`define XPS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("xps forbidden condition seen");

`else

`define XPS_ASSERT(lbl, clk, rst_n, prop)
`define XPS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- hw/rtl/xps_pkg.sv -----
// shared types and constants of the color spec parser
`default_nettype none

package xps_pkg;

	localparam int QDEPTH = 4;
	localparam int QIDX_W = $clog2(QDEPTH);
	localparam int QCNT_W = QIDX_W + 1;

	localparam logic [15:0] CH_R_LO   = 16'h0072;
	localparam logic [15:0] CH_R_UP   = 16'h0052;
	localparam logic [15:0] CH_G_LO   = 16'h0067;
	localparam logic [15:0] CH_G_UP   = 16'h0047;
	localparam logic [15:0] CH_B_LO   = 16'h0062;
	localparam logic [15:0] CH_B_UP   = 16'h0042;
	localparam logic [15:0] CH_COLON  = 16'h003A;
	localparam logic [15:0] CH_SLASH  = 16'h002F;
	localparam logic [15:0] CH_SHARP  = 16'h0023;

	localparam logic [3:0] NIB_MAX = 4'd12;
	localparam logic [2:0] DIG_MAX = 3'd4;

	typedef enum logic [2:0] {
		CL_R,
		CL_G,
		CL_B,
		CL_COLON,
		CL_SLASH,
		CL_SHARP,
		CL_OTHER
	} char_cls_t;

	// one classified character as it travels through the queue
	typedef struct packed {
		char_cls_t  cls;
		logic       is_hex;
		logic [3:0] hex;
		logic       last;
	} tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xps_char_if.sv -----
// input channel: one character per beat
`default_nettype none

interface xps_char_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        last_char;

	modport source(output valid, output char_code, output last_char, input ready);
	modport sink(input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/xps_color_if.sv -----
// output channel: one parsed color per beat
`default_nettype none

interface xps_color_if;
	logic       valid;
	logic       ready;
	logic       spec_valid;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source(output valid, output spec_valid, output red_out, output green_out,
		output blue_out, input ready);
	modport sink(input valid, input spec_valid, input red_out, input green_out,
		input blue_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/xps_front.sv -----
// front end: accepts characters and classifies them into tokens
`default_nettype none

module xps_front (
	xps_char_if.sink    chars,
	output logic        push_valid,
	output xps_pkg::tok_t push_tok,
	input  logic        push_ready
);

	logic [15:0] c;

	assign c          = chars.char_code;
	assign push_valid = chars.valid;
	assign chars.ready = push_ready;

	always_comb begin
		push_tok.last   = chars.last_char;
		push_tok.is_hex = 1'b0;
		push_tok.hex    = 4'd0;
		if (c inside {[16'h0030:16'h0039]}) begin
			push_tok.is_hex = 1'b1;
			push_tok.hex    = c[3:0];
		end else if (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]}) begin
			push_tok.is_hex = 1'b1;
			push_tok.hex    = c[3:0] + 4'd9;
		end

		if (c == xps_pkg::CH_R_LO || c == xps_pkg::CH_R_UP) begin
			push_tok.cls = xps_pkg::CL_R;
		end else if (c == xps_pkg::CH_G_LO || c == xps_pkg::CH_G_UP) begin
			push_tok.cls = xps_pkg::CL_G;
		end else if (c == xps_pkg::CH_B_LO || c == xps_pkg::CH_B_UP) begin
			push_tok.cls = xps_pkg::CL_B;
		end else if (c == xps_pkg::CH_COLON) begin
			push_tok.cls = xps_pkg::CL_COLON;
		end else if (c == xps_pkg::CH_SLASH) begin
			push_tok.cls = xps_pkg::CL_SLASH;
		end else if (c == xps_pkg::CH_SHARP) begin
			push_tok.cls = xps_pkg::CL_SHARP;
		end else begin
			push_tok.cls = xps_pkg::CL_OTHER;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/xps_fifo.sv -----
// token queue between front and back ends
`default_nettype none
`include "assert_macros.svh"

module xps_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  xps_pkg::tok_t push_tok,
	output logic          push_ready,
	output logic          pop_valid,
	output xps_pkg::tok_t pop_tok,
	input  logic          pop_ready
);

	xps_pkg::tok_t                  mem [xps_pkg::QDEPTH];
	logic [xps_pkg::QIDX_W-1:0]     wr_ptr_q;
	logic [xps_pkg::QIDX_W-1:0]     rd_ptr_q;
	logic [xps_pkg::QCNT_W-1:0]     cnt_q;
	logic                           push;
	logic                           pop;

	assign push_ready = (cnt_q != xps_pkg::QCNT_W'(xps_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_tok    = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`XPS_NEVER(a_cnt_over, clk, arst_n, cnt_q > xps_pkg::QCNT_W'(xps_pkg::QDEPTH))
	`XPS_ASSERT(a_ptr_gap, clk, arst_n, (cnt_q == '0 || cnt_q == xps_pkg::QCNT_W'(xps_pkg::QDEPTH)) == (wr_ptr_q == rd_ptr_q))
	`XPS_ASSERT(a_cnt_track, clk, arst_n, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

// ----- hw/rtl/xps_back.sv -----
// back end: parse state machine and registered color result
`default_nettype none
`include "assert_macros.svh"

module xps_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  xps_pkg::tok_t pop_tok,
	output logic          pop_ready,
	xps_color_if.source   colors
);

	typedef enum logic [2:0] {
		PH_START,
		PH_R,
		PH_RG,
		PH_RGB,
		PH_FIELDS,
		PH_SHARP,
		PH_ERROR
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  comp_q, comp_n;
	logic [2:0]  dcnt_q, dcnt_n;
	logic [15:0] acc_q, acc_n;
	logic [7:0]  red_hold_q, red_hold_n;
	logic [7:0]  green_hold_q, green_hold_n;
	logic [47:0] nib_q, nib_n;
	logic [3:0]  ncnt_q, ncnt_n;

	logic        out_vld_q;
	logic        spec_valid_q;
	logic [7:0]  red_q, green_q, blue_q;

	logic        res_valid;
	logic [7:0]  res_r, res_g, res_b;
	logic [7:0]  fld_scaled;
	logic [7:0]  hold_scaled;
	logic        pop;

	assign pop_ready = !out_vld_q || colors.ready;
	assign pop       = pop_valid && pop_ready;

	// rgb form scaling of the field being collected
	always_comb begin
		case (dcnt_n)
			3'd1:    fld_scaled = {acc_n[3:0], acc_n[3:0]};
			3'd2:    fld_scaled = acc_n[7:0];
			3'd3:    fld_scaled = acc_n[11:4];
			3'd4:    fld_scaled = acc_n[15:8];
			default: fld_scaled = 8'd0;
		endcase
	end

	// rgb form scaling of the field closed by a slash
	always_comb begin
		case (dcnt_q)
			3'd1:    hold_scaled = {acc_q[3:0], acc_q[3:0]};
			3'd2:    hold_scaled = acc_q[7:0];
			3'd3:    hold_scaled = acc_q[11:4];
			3'd4:    hold_scaled = acc_q[15:8];
			default: hold_scaled = 8'd0;
		endcase
	end

	always_comb begin
		phase_n      = phase_q;
		comp_n       = comp_q;
		dcnt_n       = dcnt_q;
		acc_n        = acc_q;
		red_hold_n   = red_hold_q;
		green_hold_n = green_hold_q;
		nib_n        = nib_q;
		ncnt_n       = ncnt_q;
		case (phase_q)
			PH_START: begin
				if (pop_tok.cls == xps_pkg::CL_R) begin
					phase_n = PH_R;
				end else if (pop_tok.cls == xps_pkg::CL_SHARP) begin
					phase_n = PH_SHARP;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			PH_R: phase_n = (pop_tok.cls == xps_pkg::CL_G) ? PH_RG : PH_ERROR;
			PH_RG: phase_n = (pop_tok.cls == xps_pkg::CL_B) ? PH_RGB : PH_ERROR;
			PH_RGB: phase_n = (pop_tok.cls == xps_pkg::CL_COLON) ? PH_FIELDS : PH_ERROR;
			PH_FIELDS: begin
				if (pop_tok.is_hex) begin
					if (dcnt_q >= xps_pkg::DIG_MAX) begin
						phase_n = PH_ERROR;
					end else begin
						acc_n  = {acc_q[11:0], pop_tok.hex};
						dcnt_n = dcnt_q + 3'd1;
					end
				end else if (pop_tok.cls == xps_pkg::CL_SLASH && comp_q < 2'd2
						&& dcnt_q != 3'd0) begin
					if (comp_q == 2'd0) begin
						red_hold_n = hold_scaled;
					end else begin
						green_hold_n = hold_scaled;
					end
					comp_n = comp_q + 2'd1;
					dcnt_n = 3'd0;
					acc_n  = 16'd0;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			PH_SHARP: begin
				if (pop_tok.is_hex && ncnt_q < xps_pkg::NIB_MAX) begin
					nib_n  = {nib_q[43:0], pop_tok.hex};
					ncnt_n = ncnt_q + 4'd1;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			default: phase_n = PH_ERROR;
		endcase
	end

	// result from the state after this character
	always_comb begin
		res_valid = 1'b0;
		res_r     = 8'd0;
		res_g     = 8'd0;
		res_b     = 8'd0;
		if (phase_n == PH_FIELDS && comp_n == 2'd2 && dcnt_n != 3'd0) begin
			res_valid = 1'b1;
			res_r     = red_hold_n;
			res_g     = green_hold_n;
			res_b     = fld_scaled;
		end else if (phase_n == PH_SHARP) begin
			res_valid = 1'b1;
			case (ncnt_n)
				4'd3: begin
					res_r = {nib_n[11:8], 4'd0};
					res_g = {nib_n[7:4], 4'd0};
					res_b = {nib_n[3:0], 4'd0};
				end
				4'd6: begin
					res_r = nib_n[23:16];
					res_g = nib_n[15:8];
					res_b = nib_n[7:0];
				end
				4'd9: begin
					res_r = nib_n[35:28];
					res_g = nib_n[23:16];
					res_b = nib_n[11:4];
				end
				4'd12: begin
					res_r = nib_n[47:40];
					res_g = nib_n[31:24];
					res_b = nib_n[15:8];
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			comp_q       <= 2'd0;
			dcnt_q       <= 3'd0;
			acc_q        <= 16'd0;
			red_hold_q   <= 8'd0;
			green_hold_q <= 8'd0;
			nib_q        <= 48'd0;
			ncnt_q       <= 4'd0;
			out_vld_q    <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_tok.last) begin
					phase_q      <= PH_START;
					comp_q       <= 2'd0;
					dcnt_q       <= 3'd0;
					acc_q        <= 16'd0;
					red_hold_q   <= 8'd0;
					green_hold_q <= 8'd0;
					nib_q        <= 48'd0;
					ncnt_q       <= 4'd0;
				end else begin
					phase_q      <= phase_n;
					comp_q       <= comp_n;
					dcnt_q       <= dcnt_n;
					acc_q        <= acc_n;
					red_hold_q   <= red_hold_n;
					green_hold_q <= green_hold_n;
					nib_q        <= nib_n;
					ncnt_q       <= ncnt_n;
				end
			end
			if (pop && pop_tok.last) begin
				out_vld_q <= 1'b1;
			end else if (colors.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_tok.last) begin
			spec_valid_q <= res_valid;
			red_q        <= res_r;
			green_q      <= res_g;
			blue_q       <= res_b;
		end
	end

	assign colors.valid      = out_vld_q;
	assign colors.spec_valid = spec_valid_q;
	assign colors.red_out    = red_q;
	assign colors.green_out  = green_q;
	assign colors.blue_out   = blue_q;

	`XPS_ASSERT(a_inv_zero, clk, arst_n, (out_vld_q && !spec_valid_q) |->
		(red_q == 8'd0 && green_q == 8'd0 && blue_q == 8'd0))
	`XPS_ASSERT(a_end_clear, clk, arst_n, (pop && pop_tok.last) |=>
		(phase_q == PH_START && ncnt_q == 4'd0 && dcnt_q == 3'd0))
	`XPS_NEVER(a_cnt_range, clk, arst_n, ncnt_q > xps_pkg::NIB_MAX || dcnt_q > xps_pkg::DIG_MAX)

endmodule

`default_nettype wire

// ----- hw/rtl/xparsecolor_spec_parser.sv -----
// top level of the color spec parser
`default_nettype none

// Parses "rgb:r/g/b" and "#rgb"-style color specs one 16-bit character per
// beat, and returns one result beat (spec_valid plus 8-bit red, green, blue,
// all zero when invalid) for the beat that carries last_char. A character is
// taken every cycle while the four-entry token queue has room; the parse
// state machine in the back end retires one token per cycle while results
// are taken, so the sustained rate is one character per cycle. The result
// beat is registered: the last token is queued, popped by the back end
// and loaded into its output register; a held result stalls the back end
// only, not the input side, until the queue fills.
module xparsecolor_spec_parser (
	input  logic        clk,
	input  logic        arst_n,
	xps_char_if.sink    chars,
	xps_color_if.source colors
);

	logic          push_valid;
	logic          push_ready;
	xps_pkg::tok_t push_tok;
	logic          pop_valid;
	logic          pop_ready;
	xps_pkg::tok_t pop_tok;

	xps_front u_front (
		.chars      (chars),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.push_ready (push_ready)
	);

	xps_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_tok    (pop_tok),
		.pop_ready  (pop_ready)
	);

	xps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_tok   (pop_tok),
		.pop_ready (pop_ready),
		.colors    (colors)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for xparsecolor_spec_parser: random spec strings with a scoreboard on results
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_CHARS = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
	localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_UPPER_F = 16'h0046;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;
	localparam logic [15:0] CH_LOWER_F = 16'h0066;

	localparam int MUL_RGB_ONE   = 17;
	localparam int MUL_SHARP_ONE = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_R,
		ST_RG,
		ST_RGB,
		ST_FIELDS,
		ST_SHARP,
		ST_BAD
	} spec_state_t;

	typedef struct {
		logic       ok;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} parsed_color_t;

	class color_scoreboard;
		spec_state_t   state;
		logic [1:0]    field_idx;
		logic [2:0]    ndigits;
		logic [15:0]   field_acc;
		logic [7:0]    red_hold;
		logic [7:0]    green_hold;
		logic [47:0]   nibbles;
		logic [3:0]    nnibbles;
		parsed_color_t color_q[$];
		int            failures;

		function new();
			failures = 0;
			clear();
		endfunction

		function void clear();
			state      = ST_IDLE;
			field_idx  = 0;
			ndigits    = 0;
			field_acc  = 0;
			red_hold   = 0;
			green_hold = 0;
			nibbles    = 0;
			nnibbles   = 0;
		endfunction

		static function int hex_of(logic [15:0] c);
			if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0);
			if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
			if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
			return -1;
		endfunction

		static function logic [7:0] scale_field(logic [15:0] v, int n, int mul);
			case (n)
				1: return 8'(v * mul);
				2: return v[7:0];
				3: return v[11:4];
				4: return v[15:8];
				default: return 8'h00;
			endcase
		endfunction

		function void note_char(logic [15:0] c, logic last);
			int            d;
			int            n;
			int            w;
			logic [47:0]   fmask;
			logic [7:0]    s;
			parsed_color_t res;
			d = hex_of(c);
			case (state)
				ST_IDLE: begin
					if (c == xps_pkg::CH_R_LO || c == xps_pkg::CH_R_UP) state = ST_R;
					else if (c == xps_pkg::CH_SHARP) state = ST_SHARP;
					else state = ST_BAD;
				end
				ST_R: state = (c == xps_pkg::CH_G_LO || c == xps_pkg::CH_G_UP) ? ST_RG : ST_BAD;
				ST_RG: state = (c == xps_pkg::CH_B_LO || c == xps_pkg::CH_B_UP) ? ST_RGB : ST_BAD;
				ST_RGB: state = (c == xps_pkg::CH_COLON) ? ST_FIELDS : ST_BAD;
				ST_FIELDS: begin
					if (d >= 0) begin
						if (ndigits >= xps_pkg::DIG_MAX) begin
							state = ST_BAD;
						end else begin
							field_acc = {field_acc[11:0], 4'(d)};
							ndigits++;
						end
					end else if (c == xps_pkg::CH_SLASH && field_idx < 2 && ndigits >= 1) begin
						s = scale_field(field_acc, int'(ndigits), MUL_RGB_ONE);
						if (field_idx == 0) red_hold = s;
						else green_hold = s;
						field_idx++;
						ndigits   = 0;
						field_acc = 0;
					end else begin
						state = ST_BAD;
					end
				end
				ST_SHARP: begin
					if (d >= 0 && nnibbles < xps_pkg::NIB_MAX) begin
						nibbles = {nibbles[43:0], 4'(d)};
						nnibbles++;
					end else begin
						state = ST_BAD;
					end
				end
				default: state = ST_BAD;
			endcase
			if (!last) return;

			res = '{1'b0, 8'h00, 8'h00, 8'h00};
			if (state == ST_FIELDS && field_idx == 2 && ndigits >= 1) begin
				res = '{1'b1, red_hold, green_hold,
					scale_field(field_acc, int'(ndigits), MUL_RGB_ONE)};
			end else if (state == ST_SHARP && nnibbles != 0 && nnibbles % 3 == 0) begin
				// the digits split into three equal fields, red in the top third
				n     = int'(nnibbles) / 3;
				w     = 4 * n;
				fmask = (48'd1 << w) - 48'd1;
				res.ok    = 1'b1;
				res.red   = scale_field(16'((nibbles >> (2 * w)) & fmask), n, MUL_SHARP_ONE);
				res.green = scale_field(16'((nibbles >> w) & fmask), n, MUL_SHARP_ONE);
				res.blue  = scale_field(16'(nibbles & fmask), n, MUL_SHARP_ONE);
			end
			color_q.insert(color_q.size(), res);
			clear();
		endfunction

		function void check_color(logic ok, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			parsed_color_t want;
			if (color_q.size() == 0) begin
				$error("color beat with nothing expected: spec_valid=%0b red=%0d green=%0d blue=%0d",
					ok, r, g, b);
				failures++;
				return;
			end
			want = color_q.pop_front();
			if (ok !== want.ok) begin
				$error("spec_valid mismatch: expected %0b, actual %0b", want.ok, ok);
				failures++;
			end
			if (r !== want.red) begin
				$error("red_out mismatch: expected %0d, actual %0d", want.red, r);
				failures++;
			end
			if (g !== want.green) begin
				$error("green_out mismatch: expected %0d, actual %0d", want.green, g);
				failures++;
			end
			if (b !== want.blue) begin
				$error("blue_out mismatch: expected %0d, actual %0d", want.blue, b);
				failures++;
			end
		endfunction

		function int pending();
			return color_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xps_char_if  chars();
	xps_color_if colors();

	xparsecolor_spec_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.colors (colors)
	);

	color_scoreboard sb = new();

	logic [15:0] spec_q[$];
	int          chars_sent = 0;
	int          run_left = 0;
	int          cycle_count = 0;
	bit          hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		if (pick < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] hex_char(int d);
		if (d < 10) return CH_DIGIT_0 + 16'(d);
		if ($urandom_range(0, 1) == 1) return CH_LOWER_A + 16'(d - 10);
		return CH_UPPER_A + 16'(d - 10);
	endfunction

	// appends one character to the spec string being built
	function automatic void add_char(logic [15:0] c);
		spec_q.insert(spec_q.size(), c);
	endfunction

	// sends the spec string held in spec_q, last_char on its final beat
	task automatic send_spec();
		int gap;
		foreach (spec_q[i]) begin
			if (run_left > 0) begin
				gap = 0;
				run_left--;
			end else begin
				gap = idle_len();
				if ($urandom_range(0, 24) == 0) run_left = $urandom_range(20, 80);
			end
			if (gap > 0) begin
				chars.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			chars.valid     <= 1'b1;
			chars.char_code <= spec_q[i];
			chars.last_char <= (i == spec_q.size() - 1);
			@(posedge clk);
			while (chars.ready !== 1'b1) @(posedge clk);
			chars_sent++;
		end
	endtask

	task automatic send_text(input string s);
		spec_q.delete();
		for (int i = 0; i < s.len(); i++) add_char({8'h00, s[i]});
		send_spec();
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && chars.valid === 1'b1 && chars.ready === 1'b1)
			sb.note_char(chars.char_code, chars.last_char);
		if (arst_n === 1'b1 && colors.valid === 1'b1 && colors.ready === 1'b1)
			sb.check_color(colors.spec_valid, colors.red_out, colors.green_out, colors.blue_out);
	end

	// result side: random stalls, clean stretches, and one long hold on request
	initial begin
		int n;
		colors.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				colors.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				colors.ready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				n = idle_len();
				if (n > 0) begin
					colors.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				colors.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int  pick;
		int  nd;
		int  idx;
		int  keep;
		bit  hold_done;
		bit  pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		chars.valid     <= 1'b0;
		chars.char_code <= 16'h0000;
		chars.last_char <= 1'b0;
		arst_n          <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone sharp, non-ascii and nul strings, bare prefix, then two good specs and a four-digit sharp spec
		send_text("#");
		spec_q = {16'hFFFF};
		send_spec();
		spec_q = {16'h0000};
		send_spec();
		send_text("RGB:");
		send_text("#fFf");
		send_text("rgB:A/b0/c");
		send_text("#0123");

		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			if (!hold_done && chars_sent >= 300) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && chars_sent >= 1000) begin
				// let every outstanding result drain before going on
				chars.valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				pause_done = 1'b1;
			end

			spec_q.delete();
			pick = $urandom_range(0, 99);
			if (pick < 90) begin
				if ($urandom_range(0, 1) == 1) begin
					add_char($urandom_range(0, 1) ? xps_pkg::CH_R_LO : xps_pkg::CH_R_UP);
					add_char($urandom_range(0, 1) ? xps_pkg::CH_G_LO : xps_pkg::CH_G_UP);
					add_char($urandom_range(0, 1) ? xps_pkg::CH_B_LO : xps_pkg::CH_B_UP);
					add_char(xps_pkg::CH_COLON);
					for (int f = 0; f < 3; f++) begin
						nd = $urandom_range(1, 4);
						repeat (nd) add_char(hex_char($urandom_range(0, 15)));
						if (f < 2) add_char(xps_pkg::CH_SLASH);
					end
				end else begin
					add_char(xps_pkg::CH_SHARP);
					nd = $urandom_range(1, 4);
					repeat (3 * nd) add_char(hex_char($urandom_range(0, 15)));
				end
				if (pick >= 65) begin
					// break the well-formed string in one place
					idx = $urandom_range(0, spec_q.size() - 1);
					case ($urandom_range(0, 3))
						0: begin
							case ($urandom_range(0, 2))
								0: spec_q[idx] = 16'($urandom_range(0, 65535));
								1: spec_q[idx] = spec_q[idx] ^ (16'h0001 << $urandom_range(8, 15));
								default: begin
									case ($urandom_range(0, 3))
										0: spec_q[idx] = xps_pkg::CH_SLASH;
										1: spec_q[idx] = xps_pkg::CH_COLON;
										2: spec_q[idx] = xps_pkg::CH_SHARP;
										default: spec_q[idx] = xps_pkg::CH_G_UP;
									endcase
								end
							endcase
						end
						1: begin
							keep = $urandom_range(1, spec_q.size() - 1);
							while (spec_q.size() > keep) void'(spec_q.pop_back());
						end
						2: spec_q.insert($urandom_range(1, spec_q.size()),
							hex_char($urandom_range(0, 15)));
						default: spec_q.delete(idx);
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 1) == 1) add_char(16'($urandom_range(0, 65535)));
					else add_char(16'($urandom_range(16'h0020, 16'h007E)));
				end
			end
			send_spec();
		end

		chars.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
